// ----- hdl/atg_pkg.sv -----
// package for the action handshake timeout guard: codes, widths and reset values
`timescale 1ns / 1ps
`default_nettype none
package atg_pkg;

  localparam int TIME_W        = 32;
  localparam int TIMEOUT_W     = 16;
  localparam int REPORT_CNT_W  = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int COUNTER_W_DEF = 16;

  localparam logic [TIMEOUT_W-1:0] TX_TIMEOUT_RST        = 16'd100;
  localparam logic [TIMEOUT_W-1:0] STARTED_TIMEOUT_RST   = 16'd500;
  localparam logic [TIMEOUT_W-1:0] COMPLETED_TIMEOUT_RST = 16'd10000;

  typedef enum logic [2:0] {
    CMD_BEGIN     = 3'd0,
    CMD_CANCEL    = 3'd1,
    CMD_TX_DONE   = 3'd2,
    CMD_STARTED   = 3'd3,
    CMD_COMPLETED = 3'd4,
    CMD_FORCE     = 3'd5,
    CMD_POLL      = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE           = 3'd0,
    PH_WAIT_TX        = 3'd1,
    PH_WAIT_STARTED   = 3'd2,
    PH_WAIT_COMPLETED = 3'd3,
    PH_FAULT          = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PARAM = 2'd1,
    ST_FAULT     = 2'd2,
    ST_BUSY      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TO_NONE      = 2'd0,
    TO_TX        = 2'd1,
    TO_STARTED   = 2'd2,
    TO_COMPLETED = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TX_TIMEOUT        = 2'd0,
    REG_STARTED_TIMEOUT   = 2'd1,
    REG_COMPLETED_TIMEOUT = 2'd2
  } reg_index_t;

endpackage
`default_nettype wire

// ----- hdl/atg_channels.sv -----
// valid/ready channel interfaces for event beats and result beats
`timescale 1ns / 1ps
`default_nettype none
interface atg_req_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    cmd;
  logic [atg_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, output cmd, output now_ms, input ready);
  modport sink   (input valid, input cmd, input now_ms, output ready);
endinterface

interface atg_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [1:0]                          timeout_kind;
  logic                                busy_flag;
  logic [2:0]                          phase_now;
  logic                                fault_flag;
  logic [atg_pkg::REPORT_CNT_W-1:0]    timeouts_seen;
  logic [atg_pkg::REPORT_CNT_W-1:0]    rejects_seen;

  modport source (output valid, output status, output timeout_kind, output busy_flag,
                  output phase_now, output fault_flag, output timeouts_seen,
                  output rejects_seen, input ready);
  modport sink   (input valid, input status, input timeout_kind, input busy_flag,
                  input phase_now, input fault_flag, input timeouts_seen,
                  input rejects_seen, output ready);
endinterface
`default_nettype wire

// ----- hdl/action_handshake_timeout_guard.sv -----
// top level of the action handshake timeout guard
`timescale 1ns / 1ps
`default_nettype none
//
// channel   dir  beat contents
// --------  ---  ------------------------------------------------------------
// req       in   cmd, now_ms
// rsp       out  status, timeout_kind, busy_flag, phase_now, fault_flag,
//                timeouts_seen, rejects_seen
// cfg_*     in   cfg_write, cfg_index, cfg_data (write only, no back-pressure)
//
// one event beat per cycle while rsp is not stalled; its result beat is registered at acceptance
// the phase, deadline and counters update at the accept edge, so the next beat
// sees them at once; the cost per beat is one 32-bit add and one 32-bit subtract
// req.ready is high while the result register is empty or being drained
// synchronous reset restores the phase to idle, clears counters and loads the
// default timeouts; rsp stalls hold the result register and back up req
//
module action_handshake_timeout_guard #(
  parameter int COUNTER_WIDTH = atg_pkg::COUNTER_W_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [atg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [atg_pkg::TIMEOUT_W-1:0]      cfg_data,
  atg_req_if.sink                                 req,
  atg_rsp_if.source                               rsp
);

  // width for widening a counter to the reporting width when it is narrower
  localparam int EXT_W = (COUNTER_WIDTH > atg_pkg::REPORT_CNT_W) ?
                         COUNTER_WIDTH : atg_pkg::REPORT_CNT_W;

  // configuration registers
  logic [atg_pkg::TIMEOUT_W-1:0] tx_timeout;
  logic [atg_pkg::TIMEOUT_W-1:0] started_timeout;
  logic [atg_pkg::TIMEOUT_W-1:0] completed_timeout;

  // supervisor state
  atg_pkg::phase_t              phase, phase_next;
  logic [atg_pkg::TIME_W-1:0]   deadline, deadline_next;
  logic                         fault, fault_next;
  logic [COUNTER_WIDTH-1:0]     timeouts, timeouts_next;
  logic [COUNTER_WIDTH-1:0]     rejects, rejects_next;

  // per-beat result
  atg_pkg::status_t             status_next;
  atg_pkg::kind_t               kind_next;

  logic                         accept;
  logic                         reached;
  logic [atg_pkg::TIME_W-1:0]   since_deadline;
  logic [EXT_W-1:0]             timeouts_ext;
  logic [EXT_W-1:0]             rejects_ext;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // wrap-safe deadline test: sign bit of now minus deadline
  assign since_deadline = req.now_ms - deadline;
  assign reached        = !since_deadline[atg_pkg::TIME_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_timeout        <= atg_pkg::TX_TIMEOUT_RST;
      started_timeout   <= atg_pkg::STARTED_TIMEOUT_RST;
      completed_timeout <= atg_pkg::COMPLETED_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        atg_pkg::REG_TX_TIMEOUT:        tx_timeout        <= cfg_data;
        atg_pkg::REG_STARTED_TIMEOUT:   started_timeout   <= cfg_data;
        atg_pkg::REG_COMPLETED_TIMEOUT: completed_timeout <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // next state of the supervisor for the beat on req
  always_comb begin
    phase_next    = phase;
    deadline_next = deadline;
    fault_next    = fault;
    timeouts_next = timeouts;
    rejects_next  = rejects;
    unique case (req.cmd)
      atg_pkg::CMD_BEGIN: begin
        if (tx_timeout != '0 && !fault) begin
          if (phase != atg_pkg::PH_IDLE) begin
            // busy: only this answer counts a reject
            if (rejects != {COUNTER_WIDTH{1'b1}}) begin
              rejects_next = rejects + COUNTER_WIDTH'(1);
            end
          end else begin
            phase_next    = atg_pkg::PH_WAIT_TX;
            deadline_next = req.now_ms + atg_pkg::TIME_W'(tx_timeout);
          end
        end
      end
      atg_pkg::CMD_CANCEL: begin
        if (phase == atg_pkg::PH_WAIT_TX && !fault) begin
          phase_next    = atg_pkg::PH_IDLE;
          deadline_next = '0;
        end
      end
      atg_pkg::CMD_TX_DONE: begin
        if (phase == atg_pkg::PH_WAIT_TX && started_timeout != '0) begin
          phase_next    = atg_pkg::PH_WAIT_STARTED;
          deadline_next = req.now_ms + atg_pkg::TIME_W'(started_timeout);
        end
      end
      atg_pkg::CMD_STARTED: begin
        if (!fault && completed_timeout != '0 &&
            (phase == atg_pkg::PH_WAIT_TX || phase == atg_pkg::PH_WAIT_STARTED)) begin
          phase_next    = atg_pkg::PH_WAIT_COMPLETED;
          deadline_next = req.now_ms + atg_pkg::TIME_W'(completed_timeout);
        end
      end
      atg_pkg::CMD_COMPLETED: begin
        if (!fault && phase != atg_pkg::PH_IDLE) begin
          phase_next    = atg_pkg::PH_IDLE;
          deadline_next = '0;
        end
      end
      atg_pkg::CMD_FORCE: begin
        phase_next    = atg_pkg::PH_FAULT;
        deadline_next = '0;
        fault_next    = 1'b1;
      end
      atg_pkg::CMD_POLL: begin
        if (!fault && reached &&
            (phase == atg_pkg::PH_WAIT_TX || phase == atg_pkg::PH_WAIT_STARTED ||
             phase == atg_pkg::PH_WAIT_COMPLETED)) begin
          if (timeouts != {COUNTER_WIDTH{1'b1}}) begin
            timeouts_next = timeouts + COUNTER_WIDTH'(1);
          end
          phase_next    = atg_pkg::PH_FAULT;
          deadline_next = '0;
          fault_next    = 1'b1;
        end
      end
      default: ;  // unused code leaves everything as it is
    endcase
  end

  // status and timeout report for the beat on req
  always_comb begin
    status_next = atg_pkg::ST_OK;
    kind_next   = atg_pkg::TO_NONE;
    unique case (req.cmd)
      atg_pkg::CMD_BEGIN: begin
        // bad parameter wins over fault, fault over busy
        if (tx_timeout == '0) begin
          status_next = atg_pkg::ST_BAD_PARAM;
        end else if (fault) begin
          status_next = atg_pkg::ST_FAULT;
        end else if (phase != atg_pkg::PH_IDLE) begin
          status_next = atg_pkg::ST_BUSY;
        end
      end
      atg_pkg::CMD_POLL: begin
        if (!fault && reached) begin
          unique case (phase)
            atg_pkg::PH_WAIT_TX:        kind_next = atg_pkg::TO_TX;
            atg_pkg::PH_WAIT_STARTED:   kind_next = atg_pkg::TO_STARTED;
            atg_pkg::PH_WAIT_COMPLETED: kind_next = atg_pkg::TO_COMPLETED;
            default:                    kind_next = atg_pkg::TO_NONE;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= atg_pkg::PH_IDLE;
      deadline <= '0;
      fault    <= 1'b0;
      timeouts <= '0;
      rejects  <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      deadline <= deadline_next;
      fault    <= fault_next;
      timeouts <= timeouts_next;
      rejects  <= rejects_next;
    end
  end

  // counters widened or cut to the reporting width
  assign timeouts_ext = EXT_W'(timeouts_next);
  assign rejects_ext  = EXT_W'(rejects_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status        <= status_next;
      rsp.timeout_kind  <= kind_next;
      rsp.busy_flag     <= (phase_next != atg_pkg::PH_IDLE) &&
                           (phase_next != atg_pkg::PH_FAULT);
      rsp.phase_now     <= phase_next;
      rsp.fault_flag    <= fault_next;
      rsp.timeouts_seen <= timeouts_ext[atg_pkg::REPORT_CNT_W-1:0];
      rsp.rejects_seen  <= rejects_ext[atg_pkg::REPORT_CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire
